[hdl/upsample_gradient_block_sum_top_macros.svh]
// assertion macros for the block-sum top level
`ifndef UPSAMPLE_GRADIENT_BLOCK_SUM_TOP_MACROS_SVH
`define UPSAMPLE_GRADIENT_BLOCK_SUM_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define USGBS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define USGBS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/usgbs_pkg.sv]
package usgbs_pkg;

    // default sizes of the line store and counters
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 64;
    localparam int DEF_MAX_SCALE    = 8;

    // field widths
    localparam int VALUE_W = 32;
    localparam int SUM_W   = VALUE_W + 6;
    localparam int CHAN_W  = 6;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_W - CHAN_W - ROW_W - COL_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 2'd3;

    // width used for limit comparisons, holds any limit up to 65535
    localparam int CMP_W = 16;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [8:0] width_in;
        logic [8:0] height_in;
        logic [6:0] channel_count;
        logic [3:0] scale;
    } cfg_t;

    // per-item control travelling from the sequencer to the accumulator
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              frame_last;
        logic              emit;
        logic              first;
    } tag_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [CMP_W-1:0] clamp_cfg(input logic [CMP_W-1:0] v,
                                                   input logic [CMP_W-1:0] hi);
        logic [CMP_W-1:0] r;
        if (v == '0)
            r = CMP_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

[hdl/usgbs_ctrl.sv]
module usgbs_ctrl
    import usgbs_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_SCALE    = DEF_MAX_SCALE,
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    output logic [ADDR_W-1:0] addr,
    output tag_t              tag
);

    localparam int OROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUB_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    logic [ADDR_W-1:0] out_col_reg, out_col_next;
    logic [SUB_W-1:0]  sub_col_reg, sub_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;
    logic [SUB_W-1:0]  sub_row_reg, sub_row_next;
    logic [CH_W-1:0]   chan_reg, chan_next;

    logic [CMP_W-1:0] w, h, c, s;
    logic col_end, row_end, last_col, last_row, last_chan;

    always_comb
    begin
        w = clamp_cfg(CMP_W'(cfg.width_in), CMP_W'(MAX_WIDTH));
        h = clamp_cfg(CMP_W'(cfg.height_in), CMP_W'(MAX_HEIGHT));
        c = clamp_cfg(CMP_W'(cfg.channel_count), CMP_W'(MAX_CHANNELS));
        s = clamp_cfg(CMP_W'(cfg.scale), CMP_W'(MAX_SCALE));
        col_end   = (CMP_W'(sub_col_reg) + CMP_W'(1)) >= s;
        row_end   = (CMP_W'(sub_row_reg) + CMP_W'(1)) >= s;
        last_col  = (CMP_W'(out_col_reg) + CMP_W'(1)) >= w;
        last_row  = (CMP_W'(out_row_reg) + CMP_W'(1)) >= h;
        last_chan = (CMP_W'(chan_reg) + CMP_W'(1)) >= c;
    end

    assign addr           = out_col_reg;
    assign tag.chan       = CHAN_W'(chan_reg);
    assign tag.row        = ROW_W'(out_row_reg);
    assign tag.col        = COL_W'(out_col_reg);
    assign tag.frame_last = last_col && last_row && last_chan;
    assign tag.emit       = col_end && row_end;
    assign tag.first      = (sub_row_reg == '0) && (sub_col_reg == '0);

    // raster walk: column within block, block column, row within block, block row, channel
    always_comb
    begin
        out_col_next = out_col_reg;
        sub_col_next = sub_col_reg;
        out_row_next = out_row_reg;
        sub_row_next = sub_row_reg;
        chan_next    = chan_reg;
        if (accept)
        begin
            if (!col_end)
                sub_col_next = sub_col_reg + 1'b1;
            else
            begin
                sub_col_next = '0;
                if (!last_col)
                    out_col_next = out_col_reg + 1'b1;
                else
                begin
                    out_col_next = '0;
                    if (!row_end)
                        sub_row_next = sub_row_reg + 1'b1;
                    else
                    begin
                        sub_row_next = '0;
                        if (!last_row)
                            out_row_next = out_row_reg + 1'b1;
                        else
                        begin
                            out_row_next = '0;
                            chan_next    = last_chan ? '0 : chan_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_col_reg <= '0;
            sub_col_reg <= '0;
            out_row_reg <= '0;
            sub_row_reg <= '0;
            chan_reg    <= '0;
        end
        else
        begin
            out_col_reg <= out_col_next;
            sub_col_reg <= sub_col_next;
            out_row_reg <= out_row_next;
            sub_row_reg <= sub_row_next;
            chan_reg    <= chan_next;
        end
    end

endmodule

[hdl/usgbs_accum.sv]
module usgbs_accum
    import usgbs_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [ADDR_W-1:0]        in_addr,
    input  tag_t                     in_tag,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic                     advance,
    output logic                     s1_valid,
    output tag_t                     s1_tag,
    output logic signed [SUM_W-1:0]  s1_sum,
    output logic                     wr_en,
    output logic [ADDR_W-1:0]        wr_addr,
    output logic                     fwd_hit
);

    // line store, one partial sum per block column
    logic signed [SUM_W-1:0] mem [MAX_WIDTH];

    logic                     s1_valid_reg, s1_valid_next;
    tag_t                     tag_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [SUM_W-1:0]  rd_data_reg;
    logic                     fwd_hit_reg;
    logic signed [SUM_W-1:0]  fwd_data_reg;

    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W:0]   wide_sum;
    logic signed [SUM_W-1:0] acc;

    always_comb
    begin
        base     = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        wide_sum = (SUM_W+1)'(base) + (SUM_W+1)'(value_reg);
        if (tag_reg.first)
            acc = SUM_W'(value_reg);
        else if (wide_sum[SUM_W] != wide_sum[SUM_W-1])
            acc = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            acc = wide_sum[SUM_W-1:0];
    end

    assign wr_en    = s1_valid_reg && advance;
    assign wr_addr  = addr_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_tag   = tag_reg;
    assign s1_sum   = acc;
    assign fwd_hit  = fwd_hit_reg;

    always_comb
    begin
        if (in_valid)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // write-back and read share the edge; the read sees the old entry,
    // so a write to the same column at that edge is caught for forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_reg] <= acc;
        if (in_valid)
        begin
            rd_data_reg  <= mem[in_addr];
            fwd_hit_reg  <= wr_en && (addr_reg == in_addr);
            fwd_data_reg <= acc;
            tag_reg      <= in_tag;
            addr_reg     <= in_addr;
            value_reg    <= in_value;
        end
    end

endmodule

[hdl/upsample_gradient_block_sum_top.sv]
// datapath: an accepted item is registered in the accumulate stage, then its block sum
//   moves into the output register that drives m_tdata, which can stall the stage
// throughput: one item per cycle unless stalled, set by the single read-add-write of the
//   line store, with a one-entry forward covering back-to-back items on the same column
// reset: rst_n (async, active low) clears the raster counters and pipeline valids, sets
//   the cfg registers to 1; the line store is not cleared and needs no clearing pass
`include "upsample_gradient_block_sum_top_macros.svh"

module upsample_gradient_block_sum_top
    import usgbs_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_SCALE    = DEF_MAX_SCALE
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // grad_value[31:0]
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // block_sum[37:0], chan_index[43:38],
                                             // row_index[51:44], col_index[59:52], zero pad
    output logic                   m_tlast   // frame_last
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // configuration registers, all reset to 1
    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH_IN:      cfg_next.width_in      = cfg_wdata;
                REG_HEIGHT_IN:     cfg_next.height_in     = cfg_wdata;
                REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_wdata[6:0];
                REG_SCALE:         cfg_next.scale         = cfg_wdata[3:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // handshake and stage control
    logic              accept;
    logic              advance;
    logic [ADDR_W-1:0] rd_addr;
    tag_t              in_tag;
    logic              s1_valid;
    tag_t              s1_tag;
    logic signed [SUM_W-1:0] s1_sum;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              fwd_hit;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0] out_sum_reg;
    tag_t                    out_tag_reg;

    // the accumulate stage moves on unless it holds a result and the output
    // register is full and stalled; items with no result never wait
    assign advance  = s1_valid && (!s1_tag.emit || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid || advance;
    assign accept   = s_tvalid && s_tready;

    usgbs_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SCALE    (MAX_SCALE)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .addr   (rd_addr),
        .tag    (in_tag)
    );

    usgbs_accum #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_addr  (rd_addr),
        .in_tag   (in_tag),
        .in_value (s_tdata[VALUE_W-1:0]),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_tag   (s1_tag),
        .s1_sum   (s1_sum),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .fwd_hit  (fwd_hit)
    );

    always_comb
    begin
        if (advance && s1_tag.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_in      <= 9'd1;
            cfg_reg.height_in     <= 9'd1;
            cfg_reg.channel_count <= 7'd1;
            cfg_reg.scale         <= 4'd1;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_tag.emit)
        begin
            out_sum_reg <= s1_sum;
            out_tag_reg <= s1_tag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_tag_reg.frame_last;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_tag_reg.col, out_tag_reg.row,
                       out_tag_reg.chan, out_sum_reg};

    // an empty accumulate stage always takes an item
    `USGBS_ASSERT_NOW(a_ready_when_empty, !s1_valid, s_tready, "stage empty but not ready")
    // a result leaving the accumulate stage lands in the output register
    `USGBS_ASSERT_NEXT(a_result_lands, advance && s1_tag.emit, out_valid_reg,
        "block sum dropped")
    // a read that collides with the write-back at the same edge is forwarded
    `USGBS_ASSERT_NEXT(a_forward_taken, accept && wr_en && (wr_addr == rd_addr), fwd_hit,
        "same-column write not forwarded")

endmodule
